// ===== sv/pwd_pkg.sv =====
// Shared types and constants for the PID controller with deadband.
// No dependencies; every other file in this folder refers to it by scoped names.
package pwd_pkg;

	localparam int DATA_W   = 32;
	localparam int DBAND_W  = 31;
	localparam int CHANGE_W = DATA_W + 1;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int PROD_D_W = DATA_W + CHANGE_W;
	// Three products summed exactly: the widest product plus two bits of growth
	localparam int SUM_W    = PROD_D_W + 2;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_GAIN_PROP  = 2'd0,
		CFG_GAIN_INTEG = 2'd1,
		CFG_GAIN_DERIV = 2'd2,
		CFG_DEADBAND   = 2'd3
	} cfg_reg_t;

	// Controller terms of one tick, after the error stage
	typedef struct packed {
		logic signed [DATA_W-1:0]   err;
		logic signed [DATA_W-1:0]   integ;
		logic signed [CHANGE_W-1:0] change;
	} terms_t;

	// Gain products of one tick
	typedef struct packed {
		logic signed [PROD_W-1:0]   prop;
		logic signed [PROD_W-1:0]   integ;
		logic signed [PROD_D_W-1:0] deriv;
	} prods_t;

endpackage

// ===== sv/pwd_if.sv =====
// Valid/ready channel interfaces for the PID controller: sample, drive and config.
// Depends on pwd_pkg for field widths.
interface pwd_sample_if;
	logic                             valid;
	logic                             ready;
	logic signed [pwd_pkg::DATA_W-1:0] target_value;
	logic signed [pwd_pkg::DATA_W-1:0] measured_value;
	logic                             clear_terms;

	modport source (output valid, output target_value, output measured_value,
		output clear_terms, input ready);
	modport sink (input valid, input target_value, input measured_value,
		input clear_terms, output ready);
endinterface

interface pwd_drive_if;
	logic                             valid;
	logic                             ready;
	logic signed [pwd_pkg::DATA_W-1:0] drive_value;

	modport source (output valid, output drive_value, input ready);
	modport sink (input valid, input drive_value, output ready);
endinterface

interface pwd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  index;
	logic [pwd_pkg::DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/pwd_error.sv =====
// Error stage: saturated error, deadband, integral and change; owns the controller state.
// Depends on pwd_pkg.
module pwd_error (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic signed [pwd_pkg::DATA_W-1:0] target_s1,
	input  logic signed [pwd_pkg::DATA_W-1:0] measured_s1,
	input  logic                              clear_s1,
	input  logic [pwd_pkg::DBAND_W-1:0]       deadband,
	output pwd_pkg::terms_t                   terms_s2
);

	logic signed [pwd_pkg::DATA_W-1:0]   last_error_q;
	logic signed [pwd_pkg::DATA_W-1:0]   integral_q;
	logic signed [pwd_pkg::DATA_W-1:0]   old_err;
	logic signed [pwd_pkg::DATA_W-1:0]   old_integ;
	logic signed [pwd_pkg::CHANGE_W-1:0] diff;
	logic signed [pwd_pkg::DATA_W-1:0]   diff_sat;
	logic signed [pwd_pkg::CHANGE_W-1:0] err_x;
	logic signed [pwd_pkg::CHANGE_W-1:0] band_hi;
	logic signed [pwd_pkg::CHANGE_W-1:0] band_lo;
	logic                                in_band;
	logic signed [pwd_pkg::DATA_W-1:0]   err;
	logic signed [pwd_pkg::CHANGE_W-1:0] integ_sum;
	logic signed [pwd_pkg::DATA_W-1:0]   integ;
	logic signed [pwd_pkg::CHANGE_W-1:0] change;

	// Drop the stored terms on a clear request
	assign old_err   = clear_s1 ? '0 : last_error_q;
	assign old_integ = clear_s1 ? '0 : integral_q;

	// Saturate the difference to 32 bits
	always_comb begin
		diff = {target_s1[pwd_pkg::DATA_W-1], target_s1}
			- {measured_s1[pwd_pkg::DATA_W-1], measured_s1};
		if (diff[pwd_pkg::CHANGE_W-1] != diff[pwd_pkg::DATA_W-1]) begin
			diff_sat = diff[pwd_pkg::CHANGE_W-1] ? pwd_pkg::SAT_MIN : pwd_pkg::SAT_MAX;
		end else begin
			diff_sat = diff[pwd_pkg::DATA_W-1:0];
		end
	end

	// Zero errors strictly inside the deadband
	assign err_x   = {diff_sat[pwd_pkg::DATA_W-1], diff_sat};
	assign band_hi = {2'b00, deadband};
	assign band_lo = -band_hi;
	assign in_band = (err_x < band_hi) && (err_x > band_lo);
	assign err     = in_band ? '0 : diff_sat;

	// Saturating integral and change from the previous error
	always_comb begin
		integ_sum = {old_integ[pwd_pkg::DATA_W-1], old_integ}
			+ {err[pwd_pkg::DATA_W-1], err};
		if (integ_sum[pwd_pkg::CHANGE_W-1] != integ_sum[pwd_pkg::DATA_W-1]) begin
			integ = integ_sum[pwd_pkg::CHANGE_W-1] ? pwd_pkg::SAT_MIN : pwd_pkg::SAT_MAX;
		end else begin
			integ = integ_sum[pwd_pkg::DATA_W-1:0];
		end
		change = {err[pwd_pkg::DATA_W-1], err} - {old_err[pwd_pkg::DATA_W-1], old_err};
	end

	// Controller state advances with each request leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			integral_q   <= '0;
		end else if (adv) begin
			last_error_q <= err;
			integral_q   <= integ;
		end
	end

	// Stage register toward the multipliers
	always_ff @(posedge clk) begin
		if (adv) begin
			terms_s2.err    <= err;
			terms_s2.integ  <= integ;
			terms_s2.change <= change;
		end
	end

endmodule

// ===== sv/pwd_mult.sv =====
// Multiplier stage: the three gain products, registered.
// Depends on pwd_pkg.
module pwd_mult (
	input  logic                              clk,
	input  logic                              adv,
	input  logic signed [pwd_pkg::DATA_W-1:0] gain_prop,
	input  logic signed [pwd_pkg::DATA_W-1:0] gain_integ,
	input  logic signed [pwd_pkg::DATA_W-1:0] gain_deriv,
	input  pwd_pkg::terms_t                   terms_s2,
	output pwd_pkg::prods_t                   prods_s3
);

	logic signed [pwd_pkg::PROD_W-1:0]   p_prop;
	logic signed [pwd_pkg::PROD_W-1:0]   p_integ;
	logic signed [pwd_pkg::PROD_D_W-1:0] p_deriv;
	logic signed [pwd_pkg::DATA_W-1:0]   t_err;
	logic signed [pwd_pkg::DATA_W-1:0]   t_integ;
	logic signed [pwd_pkg::CHANGE_W-1:0] t_change;

	assign t_err    = terms_s2.err;
	assign t_integ  = terms_s2.integ;
	assign t_change = terms_s2.change;

	// Signed full-width products
	assign p_prop  = pwd_pkg::PROD_W'(gain_prop) * pwd_pkg::PROD_W'(t_err);
	assign p_integ = pwd_pkg::PROD_W'(gain_integ) * pwd_pkg::PROD_W'(t_integ);
	assign p_deriv = pwd_pkg::PROD_D_W'(gain_deriv) * pwd_pkg::PROD_D_W'(t_change);

	always_ff @(posedge clk) begin
		if (adv) begin
			prods_s3.prop  <= p_prop;
			prods_s3.integ <= p_integ;
			prods_s3.deriv <= p_deriv;
		end
	end

endmodule

// ===== sv/pwd_sum.sv =====
// Output stage: exact sum of the products, arithmetic shift, saturation to 32 bits.
// Depends on pwd_pkg.
module pwd_sum #(
	parameter int GAIN_SHIFT = 16
) (
	input  logic                              clk,
	input  logic                              adv,
	input  pwd_pkg::prods_t                   prods_s3,
	output logic signed [pwd_pkg::DATA_W-1:0] drive_s4
);

	logic signed [pwd_pkg::PROD_W-1:0]   a_prop;
	logic signed [pwd_pkg::PROD_W-1:0]   a_integ;
	logic signed [pwd_pkg::PROD_D_W-1:0] a_deriv;
	logic signed [pwd_pkg::SUM_W-1:0]    sum;
	logic signed [pwd_pkg::SUM_W-1:0]    shifted;
	logic [pwd_pkg::SUM_W-pwd_pkg::DATA_W:0] top_bits;
	logic signed [pwd_pkg::DATA_W-1:0]   sat;

	assign a_prop  = prods_s3.prop;
	assign a_integ = prods_s3.integ;
	assign a_deriv = prods_s3.deriv;

	// Sign-extend and add without wrap
	assign sum = pwd_pkg::SUM_W'(a_prop) + pwd_pkg::SUM_W'(a_integ)
		+ pwd_pkg::SUM_W'(a_deriv);
	assign shifted = sum >>> GAIN_SHIFT;

	// Saturate when the bits above the result are not all copies of its sign
	assign top_bits = shifted[pwd_pkg::SUM_W-1:pwd_pkg::DATA_W-1];
	always_comb begin
		if ((top_bits == '0) || (top_bits == '1)) begin
			sat = shifted[pwd_pkg::DATA_W-1:0];
		end else begin
			sat = shifted[pwd_pkg::SUM_W-1] ? pwd_pkg::SAT_MIN : pwd_pkg::SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_s4 <= sat;
		end
	end

endmodule

// ===== sv/pid_with_deadband.sv =====
// PID controller with deadband, top level: handshake, config registers, pipeline.
// Depends on pwd_pkg, pwd_if, pwd_error, pwd_mult and pwd_sum.
//
// Usage: each request on the sample channel carries a target, a measured value
// and a clear flag; the block answers with exactly one drive value on the drive
// channel, in request order. Gains and deadband are written on the cfg channel
// (index 0 proportional, 1 integral, 2 derivative, 3 deadband) while idle; the
// cfg channel is always ready.
// Pipeline: an accepted sample passes the input register, error stage, multiplier
// stage and output register before its drive value is valid.
// Throughput: one sample per cycle while drive.ready stays high; the four-stage
// pipeline advances unless stalled, with the three multipliers in their own stage.
// Stall: when the receiver holds ready low, the output register holds its value
// and the stages behind it keep filling; sample.ready falls only once every
// stage is occupied.
// Reset: arst_n clears all gains, the deadband, the stored error, the integral
// and every stage valid bit; the block is ready for samples as soon as reset
// is released.
module pid_with_deadband #(
	parameter int GAIN_SHIFT = 16
) (
	input logic             clk,
	input logic             arst_n,
	pwd_sample_if.sink      sample,
	pwd_drive_if.source     drive,
	pwd_cfg_if.sink         cfg
);

	logic signed [pwd_pkg::DATA_W-1:0] gain_prop_q;
	logic signed [pwd_pkg::DATA_W-1:0] gain_integ_q;
	logic signed [pwd_pkg::DATA_W-1:0] gain_deriv_q;
	logic [pwd_pkg::DBAND_W-1:0]       deadband_q;

	logic                              valid_s1;
	logic                              valid_s2;
	logic                              valid_s3;
	logic                              valid_s4;
	logic                              en1;
	logic                              en2;
	logic                              en3;
	logic                              en4;

	logic signed [pwd_pkg::DATA_W-1:0] target_s1;
	logic signed [pwd_pkg::DATA_W-1:0] measured_s1;
	logic                              clear_s1;
	pwd_pkg::terms_t                   terms_s2;
	pwd_pkg::prods_t                   prods_s3;
	logic signed [pwd_pkg::DATA_W-1:0] drive_s4;

	// Configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			deadband_q   <= '0;
		end else if (cfg.valid) begin
			unique case (pwd_pkg::cfg_reg_t'(cfg.index))
				pwd_pkg::CFG_GAIN_PROP:  gain_prop_q  <= cfg.data;
				pwd_pkg::CFG_GAIN_INTEG: gain_integ_q <= cfg.data;
				pwd_pkg::CFG_GAIN_DERIV: gain_deriv_q <= cfg.data;
				pwd_pkg::CFG_DEADBAND:   deadband_q   <= cfg.data[pwd_pkg::DBAND_W-1:0];
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its content moves on
	assign en4 = !valid_s4 || drive.ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign sample.ready = en1;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= sample.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			target_s1   <= sample.target_value;
			measured_s1 <= sample.measured_value;
			clear_s1    <= sample.clear_terms;
		end
	end

	pwd_error u_error (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (en2 && valid_s1),
		.target_s1   (target_s1),
		.measured_s1 (measured_s1),
		.clear_s1    (clear_s1),
		.deadband    (deadband_q),
		.terms_s2    (terms_s2)
	);

	pwd_mult u_mult (
		.clk        (clk),
		.adv        (en3 && valid_s2),
		.gain_prop  (gain_prop_q),
		.gain_integ (gain_integ_q),
		.gain_deriv (gain_deriv_q),
		.terms_s2   (terms_s2),
		.prods_s3   (prods_s3)
	);

	pwd_sum #(
		.GAIN_SHIFT (GAIN_SHIFT)
	) u_sum (
		.clk      (clk),
		.adv      (en4 && valid_s3),
		.prods_s3 (prods_s3),
		.drive_s4 (drive_s4)
	);

	assign drive.valid       = valid_s4;
	assign drive.drive_value = drive_s4;

	// An accepted request occupies the input register next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> valid_s1)
		else $error("accepted request missing from input register");

	// A request leaving the input register lands in the error stage
	a_error_fills: assert property (@(posedge clk) disable iff (!arst_n)
		en2 && valid_s1 |=> valid_s2)
		else $error("request lost between input and error stage");

	// A blocked product stage keeps its request
	a_mult_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !en4 |=> valid_s3 && $stable(prods_s3))
		else $error("multiplier stage dropped or changed a stalled request");

	// A full pipeline whose output is stalled does not take new requests
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && !drive.ready |-> !sample.ready)
		else $error("request taken while every stage is blocked");

endmodule

// ===== tb/pid_with_deadband_tb.sv =====
// Testbench for pid_with_deadband: random and directed control ticks, drive values
// checked in order against a cycle-free predictor. Depends on pid_with_deadband, pwd_pkg and pwd_if.
module pid_with_deadband_tb;

	localparam int GAIN_SHIFT   = 16;
	localparam int NUM_SEGS     = 12;
	localparam int TICKS_PER_SEG = 135;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 8;

	localparam logic signed [pwd_pkg::DATA_W-1:0] I32_MAX = pwd_pkg::SAT_MAX;
	localparam logic signed [pwd_pkg::DATA_W-1:0] I32_MIN = pwd_pkg::SAT_MIN;

	typedef struct {
		logic signed [pwd_pkg::DATA_W-1:0] target;
		logic signed [pwd_pkg::DATA_W-1:0] measured;
		logic                              clear;
	} tick_t;

	logic clk;
	logic arst_n;

	pwd_sample_if sample_ch();
	pwd_drive_if  drive_ch();
	pwd_cfg_if    cfg_ch();

	pid_with_deadband #(.GAIN_SHIFT(GAIN_SHIFT)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.drive  (drive_ch),
		.cfg    (cfg_ch)
	);

	// Controller settings and stored terms as the block should hold them
	longint gain_p, gain_i, gain_d, band;
	longint prev_err, err_integral, err_delta;

	tick_t                             tick_queue[$];
	logic signed [pwd_pkg::DATA_W-1:0] drive_expected[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int cycle_count;

	function automatic longint sat32(longint v);
		if (v > longint'(I32_MAX))
			return longint'(I32_MAX);
		if (v < longint'(I32_MIN))
			return longint'(I32_MIN);
		return v;
	endfunction

	// Advance the stored terms by one tick and return the drive it produces
	function automatic logic signed [pwd_pkg::DATA_W-1:0] predict_drive(tick_t t);
		longint                e;
		logic signed [127:0]   kp, ki, kd, xe, xi, xd, acc;
		if (t.clear) begin
			prev_err     = 0;
			err_integral = 0;
			err_delta    = 0;
		end
		e = sat32(longint'(t.target) - longint'(t.measured));
		if (e > -band && e < band)
			e = 0;
		err_delta    = e - prev_err;
		prev_err     = e;
		err_integral = sat32(err_integral + e);
		kp = gain_p;
		ki = gain_i;
		kd = gain_d;
		xe = prev_err;
		xi = err_integral;
		xd = err_delta;
		// sum the three products exactly, then shift and clamp
		acc = (kp * xe + ki * xi + kd * xd) >>> GAIN_SHIFT;
		if (acc > 128'sh7FFF_FFFF)
			return I32_MAX;
		if (acc < -128'sh8000_0000)
			return I32_MIN;
		return acc[pwd_pkg::DATA_W-1:0];
	endfunction

	function automatic tick_t mk_tick(logic signed [pwd_pkg::DATA_W-1:0] tgt,
			logic signed [pwd_pkg::DATA_W-1:0] meas, logic clr);
		tick_t t;
		t.target   = tgt;
		t.measured = meas;
		t.clear    = clr;
		return t;
	endfunction

	function automatic logic signed [pwd_pkg::DATA_W-1:0] pick_extreme();
		case ($urandom_range(4))
			0: return I32_MIN;
			1: return I32_MAX;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// Mix full-range errors, errors around the deadband edge and extreme values
	function automatic tick_t rand_tick();
		tick_t       t;
		longint      m, d, v;
		int unsigned pick;
		pick    = $urandom_range(99);
		t.clear = ($urandom_range(19) == 0);
		if (pick < 30) begin
			t.target   = $urandom;
			t.measured = $urandom;
		end else if (pick < 80) begin
			m = longint'($signed($urandom)) >>> 1;
			case ($urandom_range(4))
				0: d = band;
				1: d = band - 1;
				2: d = band + 1;
				3: d = $urandom_range(2000);
				default: d = $urandom_range(1 << 24);
			endcase
			if ($urandom_range(1))
				d = -d;
			v = sat32(m + d);
			t.measured = m[pwd_pkg::DATA_W-1:0];
			t.target   = v[pwd_pkg::DATA_W-1:0];
		end else begin
			t.target   = pick_extreme();
			t.measured = pick_extreme();
		end
		return t;
	endfunction

	task automatic write_config(input logic [pwd_pkg::DATA_W-1:0] gp,
			input logic [pwd_pkg::DATA_W-1:0] gi,
			input logic [pwd_pkg::DATA_W-1:0] gd, input logic [pwd_pkg::DBAND_W-1:0] db);
		logic [pwd_pkg::DATA_W-1:0] vals [4];
		pwd_pkg::cfg_reg_t          idx;
		vals = '{gp, gi, gd, {1'b0, db}};
		for (int r = 0; r < 4; r++) begin
			idx = pwd_pkg::cfg_reg_t'(r);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.data  <= vals[r];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			case (idx)
				pwd_pkg::CFG_GAIN_PROP:  gain_p = longint'($signed(vals[r]));
				pwd_pkg::CFG_GAIN_INTEG: gain_i = longint'($signed(vals[r]));
				pwd_pkg::CFG_GAIN_DERIV: gain_d = longint'($signed(vals[r]));
				pwd_pkg::CFG_DEADBAND:   band   = longint'(vals[r][pwd_pkg::DBAND_W-1:0]);
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic apply_setting(int n);
		logic [pwd_pkg::DATA_W-1:0]  g [3];
		logic [pwd_pkg::DBAND_W-1:0] db;
		logic [31:0]                 rnd;
		case (n)
			0: write_config(32'h0001_0000, 32'h0000_8000, 32'hFFFF_C000, 31'd5);
			1: write_config(I32_MAX, I32_MAX, I32_MAX, 31'd0);
			2: write_config(I32_MIN, I32_MIN, I32_MIN, {pwd_pkg::DBAND_W{1'b1}});
			3: write_config(32'd0, 32'd0, 32'd0, 31'd0);
			4: write_config(32'h0001_0000, 32'd0, 32'd0, 31'd1);
			default: begin
				// each gain is either small or drawn from the full range
				for (int k = 0; k < 3; k++) begin
					if ($urandom_range(1))
						g[k] = $signed($urandom_range(1 << 19)) - (1 << 18);
					else
						g[k] = $urandom;
				end
				case ($urandom_range(3))
					0: db = '0;
					1: db = 31'd1;
					2: begin
						rnd = $urandom_range(1000);
						db  = rnd[pwd_pkg::DBAND_W-1:0];
					end
					default: begin
						rnd = $urandom;
						db  = rnd[pwd_pkg::DBAND_W-1:0];
					end
				endcase
				write_config(g[0], g[1], g[2], db);
			end
		endcase
	endtask

	// Queue deadband edges, error saturation, integral windup and clears
	task automatic queue_directed();
		tick_queue.push_back(mk_tick(0, 0, 1'b0));
		tick_queue.push_back(mk_tick(4, 0, 1'b0));
		tick_queue.push_back(mk_tick(5, 0, 1'b0));
		tick_queue.push_back(mk_tick(-4, 0, 1'b0));
		tick_queue.push_back(mk_tick(0, 5, 1'b0));
		for (int k = 0; k < 4; k++)
			tick_queue.push_back(mk_tick(I32_MAX, I32_MIN, 1'b0));
		for (int k = 0; k < 4; k++)
			tick_queue.push_back(mk_tick(I32_MIN, I32_MAX, 1'b0));
		tick_queue.push_back(mk_tick(100, 0, 1'b1));
		tick_queue.push_back(mk_tick(I32_MAX, I32_MAX, 1'b0));
		tick_queue.push_back(mk_tick(I32_MIN, I32_MIN, 1'b0));
		tick_queue.push_back(mk_tick(I32_MIN, 1, 1'b0));
		tick_queue.push_back(mk_tick(0, I32_MIN, 1'b0));
		tick_queue.push_back(mk_tick(I32_MAX, 0, 1'b0));
		tick_queue.push_back(mk_tick(I32_MIN, 0, 1'b0));
		tick_queue.push_back(mk_tick(-1, I32_MAX, 1'b1));
		tick_queue.push_back(mk_tick(-1, 0, 1'b0));
		tick_queue.push_back(mk_tick(0, 0, 1'b1));
	endtask

	task automatic report(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** pid_with_deadband: FAILED **");
			$finish;
		end
	end

	// Sample driver: present the oldest pending tick, hold it until accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_ch.valid          <= 1'b0;
			sample_ch.target_value   <= '0;
			sample_ch.measured_value <= '0;
			sample_ch.clear_terms    <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				drive_expected.push_back(predict_drive(tick_queue.pop_front()));
			if (sample_ch.valid && !sample_ch.ready) begin
				// hold the pending request
			end else if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				sample_ch.valid          <= 1'b1;
				sample_ch.target_value   <= tick_queue[0].target;
				sample_ch.measured_value <= tick_queue[0].measured;
				sample_ch.clear_terms    <= tick_queue[0].clear;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Drive monitor: stall at random and check each accepted drive value
	always @(posedge clk) begin
		logic signed [pwd_pkg::DATA_W-1:0] want;
		if (!arst_n) begin
			drive_ch.ready <= 1'b0;
		end else begin
			if (drive_ch.valid && drive_ch.ready) begin
				if (drive_expected.size() == 0) begin
					report($sformatf("unexpected drive value %0d at cycle %0d",
						drive_ch.drive_value, cycle_count));
				end else begin
					want = drive_expected.pop_front();
					if (drive_ch.drive_value !== want)
						report($sformatf("drive mismatch at cycle %0d: expected %0d, got %0d",
							cycle_count, want, drive_ch.drive_value));
				end
			end
			drive_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Reset, then run each controller setting in turn with its own batch of ticks
	initial begin
		mismatch_count = 0;
		cycle_count    = 0;
		send_idle_pct  = 22;
		recv_idle_pct  = 54;
		gain_p = 0;
		gain_i = 0;
		gain_d = 0;
		band   = 0;
		prev_err     = 0;
		err_integral = 0;
		err_delta    = 0;
		arst_n                   <= 1'b0;
		cfg_ch.valid             <= 1'b0;
		cfg_ch.index             <= pwd_pkg::CFG_GAIN_PROP;
		cfg_ch.data              <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg < NUM_SEGS / 3) begin
				send_idle_pct = 22;
				recv_idle_pct = 54;
			end else if (seg < 2 * NUM_SEGS / 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			apply_setting(seg);
			if (seg == 0)
				queue_directed();
			for (int k = 0; k < TICKS_PER_SEG; k++)
				tick_queue.push_back(rand_tick());
			// drain before touching the registers again
			while (tick_queue.size() != 0 || drive_expected.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (drive_expected.size() != 0)
			report($sformatf("%0d drive values never arrived", drive_expected.size()));
		if (mismatch_count == 0)
			$display("** pid_with_deadband: PASSED **");
		else
			$display("** pid_with_deadband: FAILED **");
		$finish;
	end

endmodule
